[src/cdd_pkg.sv]
// Shared types, constants and helpers of the cash denomination dispenser.
package cdd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int NUM_DENOMS = 15;
    localparam int AMOUNT_W   = 27;
    localparam int VALUE_W    = 16;
    localparam int BAL_W      = 33;
    localparam int IDX_W      = 4;
    // The greedy split never takes more than 2684 pieces of one denomination.
    localparam int PIECE_W    = 12;
    localparam int REM_W      = 17;
    localparam int DENOM_W    = 16;
    localparam int PROD_W     = COUNT_BITS + DENOM_W;
    localparam int CHK_W      = ((COUNT_BITS > PIECE_W) ? COUNT_BITS : PIECE_W) + 1;
    localparam int SAT_W      = (COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W;

    // Largest denomination is 16 * 3125; this is floor(2^32 / 3125).
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_IN_W  = AMOUNT_W - 4;
    localparam int RECIP_W     = 21;
    localparam int RPROD_W     = RECIP_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = 21'd1374389;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [PIECE_W-1:0]    t_piece;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [AMOUNT_W-1:0]   t_amount;
    typedef logic [BAL_W-1:0]      t_balance;
    typedef logic [1:0]            t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_LIMITS   = 2'd1;
    localparam t_status ST_STOCK    = 2'd2;
    localparam t_status ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        KIND_WITHDRAW = 2'd0,
        KIND_DEPOSIT  = 2'd1,
        KIND_LOAD     = 2'd2
    } t_kind;

    localparam logic [1:0] REG_MIN_WD = 2'd0;
    localparam logic [1:0] REG_MAX_WD = 2'd1;

    localparam logic [DENOM_W-1:0] DENOM_TAB [NUM_DENOMS] = '{
        16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd2000, 16'd1000,
        16'd500, 16'd200, 16'd100, 16'd50, 16'd25, 16'd10, 16'd5, 16'd2, 16'd1
    };

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } t_split_ctl;

    typedef struct packed {
        logic   load_we;
        t_idx   load_idx;
        t_count load_val;
        logic   piece_we;
        logic   apply_en;
        logic   sub;
        t_idx   idx;
        logic   acc_clr;
        logic   mul_en;
    } t_bank_ctl;

    typedef struct packed {
        logic short_stock;
        logic overflow;
    } t_bank_chk;

    // Saturate a loaded value to the count width.
    function automatic t_count sat_count(input logic [VALUE_W-1:0] v);
        logic [SAT_W-1:0] ext_v;
        logic [SAT_W-1:0] ext_max;
        ext_v   = SAT_W'(v);
        ext_max = SAT_W'({COUNT_BITS{1'b1}});
        if (ext_v > ext_max) begin
            return {COUNT_BITS{1'b1}};
        end
        return COUNT_BITS'(ext_v);
    endfunction

endpackage

[src/cdd_split.sv]
// Greedy split unit: one denomination per step through a shared compare-subtract.
module cdd_split (
    input  logic                i_clk,
    input  cdd_pkg::t_split_ctl i_ctl,
    input  cdd_pkg::t_amount    i_amount,
    input  cdd_pkg::t_idx       i_idx,
    output cdd_pkg::t_piece     o_pieces
);
    import cdd_pkg::*;

    t_amount            r_amt;
    logic [RPROD_W-1:0] r_prod;
    t_piece             r_qe;
    logic [REM_W-1:0]   r_rem;

    t_piece           qe;
    t_amount          qe_val;
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] d2;
    logic [1:0]       extra;
    logic [REM_W-1:0] sub_val;
    t_piece           base;

    always_comb begin
        qe     = r_prod[RPROD_W-1:RECIP_SHIFT];
        qe_val = AMOUNT_W'(qe) * AMOUNT_W'(DENOM_TAB[0]);
        d      = REM_W'(DENOM_TAB[i_idx]);
        d2     = d << 1;
        // The remainder stays below three times the current denomination.
        if (r_rem >= d2) begin
            extra   = 2'd2;
            sub_val = d2;
        end else if (r_rem >= d) begin
            extra   = 2'd1;
            sub_val = d;
        end else begin
            extra   = 2'd0;
            sub_val = '0;
        end
        base     = (i_idx == '0) ? r_qe : '0;
        o_pieces = base + PIECE_W'(extra);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_amt <= i_amount;
        end
        // Quotient estimate by the largest denomination; low by at most one.
        r_prod <= RPROD_W'(r_amt[AMOUNT_W-1:4]) * RPROD_W'(RECIP_M);
        if (i_ctl.init) begin
            r_qe  <= qe;
            r_rem <= REM_W'(r_amt - qe_val);
        end else if (i_ctl.step) begin
            r_rem <= r_rem - sub_val;
        end
    end

endmodule

[src/cdd_bank.sv]
// Denomination count store with stock checks, count update and balance sum.
module cdd_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdd_pkg::t_bank_ctl i_ctl,
    input  cdd_pkg::t_piece    i_pieces,
    output cdd_pkg::t_bank_chk o_chk,
    output cdd_pkg::t_balance  o_balance
);
    import cdd_pkg::*;

    t_count            r_counts [NUM_DENOMS];
    t_piece            r_pieces [NUM_DENOMS];
    logic [PROD_W-1:0] r_bprod;
    logic              r_acc_en;
    t_balance          r_bal;

    t_count           cnt;
    t_piece           stored_p;
    t_count           n_cnt;
    logic [CHK_W-1:0] cnt_ext;
    logic [CHK_W-1:0] p_ext;

    always_comb begin
        cnt      = r_counts[i_ctl.idx];
        stored_p = r_pieces[i_ctl.idx];
        cnt_ext  = CHK_W'(cnt);
        p_ext    = CHK_W'(i_pieces);
        o_chk.short_stock = cnt_ext < p_ext;
        o_chk.overflow    = (cnt_ext + p_ext) > CHK_W'({COUNT_BITS{1'b1}});
        // A passed check guarantees the piece count fits the count width here.
        if (!i_ctl.apply_en) begin
            n_cnt = cnt;
        end else if (i_ctl.sub) begin
            n_cnt = cnt - COUNT_BITS'(stored_p);
        end else begin
            n_cnt = cnt + COUNT_BITS'(stored_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
                r_counts[i] <= '0;
            end
            r_acc_en <= 1'b0;
        end else begin
            if (i_ctl.load_we) begin
                r_counts[i_ctl.load_idx] <= i_ctl.load_val;
            end else if (i_ctl.apply_en) begin
                r_counts[i_ctl.idx] <= n_cnt;
            end
            r_acc_en <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.piece_we) begin
            r_pieces[i_ctl.idx] <= i_pieces;
        end
        if (i_ctl.mul_en) begin
            r_bprod <= PROD_W'(n_cnt) * PROD_W'(DENOM_TAB[i_ctl.idx]);
        end
        if (i_ctl.acc_clr) begin
            r_bal <= '0;
        end else if (r_acc_en) begin
            r_bal <= r_bal + BAL_W'(r_bprod);
        end
    end

    assign o_balance = r_bal;

endmodule

[src/cash_denomination_dispenser_top.sv]
// Top level of the cash denomination dispenser: sequencer, limits and ports.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  request   | start, busy            | i_kind, i_amount, i_denom_index,
//            |                        | i_count_value
//  result    | o_done (one cycle)     | o_status, o_total_balance
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A withdrawal or deposit runs from acceptance to the result cycle through the
// quotient estimate (S_EST, S_REM), 15 split steps through the shared
// compare-subtract unit, 15 count update steps, one accumulate and the result.
// A load, an unused kind or a withdrawal outside the limits skips the split and
// goes straight to the count update steps. busy stays high through the result cycle.
// Reset is synchronous and clears all counts and restores the default limits.
// The result is shown for one cycle only and the receiver cannot stall it.
module cash_denomination_dispenser_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_kind,
    input  cdd_pkg::t_amount               i_amount,
    input  cdd_pkg::t_idx                  i_denom_index,
    input  logic [cdd_pkg::VALUE_W-1:0]    i_count_value,
    output logic                           o_done,
    output cdd_pkg::t_status               o_status,
    output cdd_pkg::t_balance              o_total_balance,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  cdd_pkg::t_amount               i_cfg_data
);
    import cdd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EST   = 7'b0000010,
        S_REM   = 7'b0000100,
        S_SPLIT = 7'b0001000,
        S_APPLY = 7'b0010000,
        S_TAIL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    t_idx       r_idx, n_idx;
    t_status    r_status, n_status;
    logic [1:0] r_kind;
    t_amount    r_min, r_max;

    logic       accept;
    logic       limit_bad;
    logic       idx_ok;
    logic       last;
    logic       is_move;
    t_split_ctl split_ctl;
    t_bank_ctl  bank_ctl;
    t_bank_chk  chk;
    t_piece     pieces;
    t_balance   balance;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign limit_bad = (i_amount < r_min) || (i_amount > r_max);
    assign idx_ok    = i_denom_index < IDX_W'(NUM_DENOMS);
    assign last      = (r_idx == IDX_W'(NUM_DENOMS - 1));
    assign is_move   = (r_kind == KIND_WITHDRAW) || (r_kind == KIND_DEPOSIT);

    always_comb begin
        split_ctl.load = accept;
        split_ctl.init = (r_state == S_REM);
        split_ctl.step = (r_state == S_SPLIT);

        bank_ctl.load_we  = accept && (i_kind == KIND_LOAD) && idx_ok;
        bank_ctl.load_idx = i_denom_index;
        bank_ctl.load_val = sat_count(i_count_value);
        bank_ctl.piece_we = (r_state == S_SPLIT);
        bank_ctl.apply_en = (r_state == S_APPLY) && is_move && (r_status == ST_OK);
        bank_ctl.sub      = (r_kind == KIND_WITHDRAW);
        bank_ctl.idx      = r_idx;
        bank_ctl.acc_clr  = accept;
        bank_ctl.mul_en   = (r_state == S_APPLY);
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx    = '0;
                    n_status = ST_OK;
                    if (i_kind == KIND_WITHDRAW && limit_bad) begin
                        n_status = ST_LIMITS;
                        n_state  = S_APPLY;
                    end else if (i_kind == KIND_WITHDRAW || i_kind == KIND_DEPOSIT) begin
                        n_state = S_EST;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_EST: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                // Any short or overflowing denomination refuses the whole transaction.
                if (r_kind == KIND_WITHDRAW && chk.short_stock) begin
                    n_status = ST_STOCK;
                end else if (r_kind == KIND_DEPOSIT && chk.overflow) begin
                    n_status = ST_OVERFLOW;
                end
                if (last) begin
                    n_idx   = '0;
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_APPLY: begin
                if (last) begin
                    n_idx   = '0;
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_min   <= AMOUNT_W'(10000);
            r_max   <= AMOUNT_W'(500000);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_WD: r_min <= i_cfg_data;
                    REG_MAX_WD: r_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (accept) begin
            r_kind <= i_kind;
        end
    end

    cdd_split u_split (
        .i_clk    (i_clk),
        .i_ctl    (split_ctl),
        .i_amount (i_amount),
        .i_idx    (r_idx),
        .o_pieces (pieces)
    );

    cdd_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (bank_ctl),
        .i_pieces  (pieces),
        .o_chk     (chk),
        .o_balance (balance)
    );

    assign o_done          = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_total_balance = balance;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block did not return to idle after the result");

    a_ovf_deposit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OVERFLOW) |-> (r_kind == KIND_DEPOSIT))
        else $error("overflow status on a transaction that is not a deposit");

    a_limits_withdraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_LIMITS) |-> (r_kind == KIND_WITHDRAW))
        else $error("limit status on a transaction that is not a withdrawal");

endmodule

[test/cdd_balance_checker.sv]
// Checker for the cash denomination dispenser: tracks counts and limits, predicts each result.
`timescale 1ns / 100ps

module cdd_balance_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_kind,
    input  cdd_pkg::t_amount            i_amount,
    input  cdd_pkg::t_idx               i_denom_index,
    input  logic [cdd_pkg::VALUE_W-1:0] i_count_value,
    input  logic                        i_done,
    input  cdd_pkg::t_status            i_status,
    input  cdd_pkg::t_balance           i_total_balance,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  cdd_pkg::t_amount            i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import cdd_pkg::*;

    typedef struct packed {
        t_status  status;
        t_balance balance;
    } t_receipt;

    localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;

    longint unsigned stock [NUM_DENOMS];
    t_amount         lim_min;
    t_amount         lim_max;
    t_receipt        receipts_due [$];
    int              mismatches = 0;

    function automatic longint unsigned kopecks_of(input int unsigned slot);
        case (slot)
            0:       return 50000;
            1:       return 20000;
            2:       return 10000;
            3:       return 5000;
            4:       return 2000;
            5:       return 1000;
            6:       return 500;
            7:       return 200;
            8:       return 100;
            9:       return 50;
            10:      return 25;
            11:      return 10;
            12:      return 5;
            13:      return 2;
            default: return 1;
        endcase
    endfunction

    // Applies one transaction to the tracked counts and returns the status and new balance.
    task automatic settle_transaction(input logic [1:0] kind, input t_amount amt,
                                      input t_idx idx, input logic [VALUE_W-1:0] val,
                                      output t_status st, output t_balance bal);
        longint unsigned pieces [NUM_DENOMS];
        longint unsigned rest;
        longint unsigned sum;
        rest = amt;
        for (int i = 0; i < NUM_DENOMS; i++) begin
            pieces[i] = rest / kopecks_of(i);
            rest      = rest - pieces[i] * kopecks_of(i);
        end
        st = ST_OK;
        case (kind)
            KIND_WITHDRAW: begin
                if (amt < lim_min || amt > lim_max) begin
                    st = ST_LIMITS;
                end else begin
                    for (int i = 0; i < NUM_DENOMS; i++) begin
                        if (stock[i] < pieces[i]) st = ST_STOCK;
                    end
                    if (st == ST_OK) begin
                        for (int i = 0; i < NUM_DENOMS; i++) stock[i] -= pieces[i];
                    end
                end
            end
            KIND_DEPOSIT: begin
                for (int i = 0; i < NUM_DENOMS; i++) begin
                    if (stock[i] + pieces[i] > COUNT_TOP) st = ST_OVERFLOW;
                end
                if (st == ST_OK) begin
                    for (int i = 0; i < NUM_DENOMS; i++) stock[i] += pieces[i];
                end
            end
            KIND_LOAD: begin
                if (idx < NUM_DENOMS) stock[idx] = (val > COUNT_TOP) ? COUNT_TOP : val;
            end
            default: ;
        endcase
        sum = 0;
        for (int i = 0; i < NUM_DENOMS; i++) sum += stock[i] * kopecks_of(i);
        bal = t_balance'(sum);
    endtask

    always @(posedge i_clk) begin
        t_receipt want;
        t_status  st;
        t_balance bal;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DENOMS; i++) stock[i] = 0;
            lim_min = 27'd10000;
            lim_max = 27'd500000;
            receipts_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MIN_WD) begin
                    lim_min = i_cfg_data;
                end else if (i_cfg_idx == REG_MAX_WD) begin
                    lim_max = i_cfg_data;
                end
            end
            if (i_start && !i_busy) begin
                settle_transaction(i_kind, i_amount, i_denom_index, i_count_value, st, bal);
                want.status  = st;
                want.balance = bal;
                receipts_due.push_back(want);
            end
            if (i_done) begin
                if (receipts_due.size() == 0) begin
                    $display("%0t: unexpected result, status %0d balance %0d",
                             $time, i_status, i_total_balance);
                    mismatches++;
                end else begin
                    want = receipts_due.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_status);
                        mismatches++;
                    end
                    if (i_total_balance !== want.balance) begin
                        $display("%0t: balance expected %0d got %0d",
                                 $time, want.balance, i_total_balance);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= receipts_due.size();
    end

endmodule

[test/cash_denomination_dispenser_top_tb.sv]
// Testbench top for the cash denomination dispenser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cash_denomination_dispenser_top_tb;
    import cdd_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;
    localparam t_idx       NO_DENOM     = 4'd15;
    localparam t_amount    AMT_ALL      = '1;
    localparam t_amount    AMT_TOP      = 27'd99999999;
    localparam int         N_PHASES     = 7;
    localparam int         PHASE_ITEMS  = 205;
    localparam int         CALM_FROM    = 700;
    localparam int         CALM_TO      = 950;
    localparam int         CYCLE_LIMIT  = 600000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_kind;
    t_amount             i_amount;
    t_idx                i_denom_index;
    logic [VALUE_W-1:0]  i_count_value;
    logic                o_done;
    t_status             o_status;
    t_balance            o_total_balance;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_idx;
    t_amount             i_cfg_data;

    int      fail_count;
    int      pending;
    int      cycles = 0;
    int      n_sent = 0;
    t_amount lim_lo;
    t_amount lim_hi;

    cash_denomination_dispenser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_amount        (i_amount),
        .i_denom_index   (i_denom_index),
        .i_count_value   (i_count_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_total_balance (o_total_balance),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    cdd_balance_checker balance_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_amount        (i_amount),
        .i_denom_index   (i_denom_index),
        .i_count_value   (i_count_value),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_total_balance (o_total_balance),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one transaction and returns at the edge where the block takes it.
    task automatic issue(input logic [1:0] kind, input t_amount amt, input t_idx idx,
                         input logic [VALUE_W-1:0] val);
        int gap;
        gap = 0;
        if (!(n_sent >= CALM_FROM && n_sent < CALM_TO) && $urandom_range(99) < 31) begin
            gap = $urandom_range(40, 1);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_amount      <= amt;
        i_denom_index <= idx;
        i_count_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
    endtask

    // Waits until every expected result has come back and the block is free.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input t_amount data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input t_amount lo, input t_amount hi);
        write_reg(REG_MIN_WD, lo);
        write_reg(REG_MAX_WD, hi);
        i_cfg_we <= 1'b0;
        lim_lo = lo;
        lim_hi = hi;
    endtask

    initial begin
        logic [1:0]         kind;
        t_amount            amt;
        t_amount            span;
        t_amount            lo;
        t_idx               idx;
        logic [VALUE_W-1:0] val;
        int                 pick;
        int                 sub;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_kind        <= KIND_WITHDRAW;
        i_amount      <= '0;
        i_denom_index <= '0;
        i_count_value <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_MIN_WD;
        i_cfg_data    <= '0;
        lim_lo = 27'd10000;
        lim_hi = 27'd500000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the default limits, starting from empty counts.
        issue(KIND_WITHDRAW, 27'd10000, '0, '0);
        issue(KIND_WITHDRAW, 27'd9999, '0, '0);
        issue(KIND_WITHDRAW, 27'd500001, '0, '0);
        issue(KIND_DEPOSIT, '0, '0, '0);
        issue(KIND_DEPOSIT, AMT_ALL, '1, '1);
        issue(KIND_DEPOSIT, AMT_TOP, '0, '0);
        issue(KIND_LOAD, '0, 4'd0, 16'hFFFF);
        issue(KIND_LOAD, '0, 4'd14, 16'hFFFF);
        issue(KIND_DEPOSIT, 27'd1, '0, '0);
        issue(KIND_DEPOSIT, 27'd50000, '0, '0);
        issue(KIND_LOAD, '0, NO_DENOM, 16'd1234);
        issue(KIND_SPARE, 27'd12345, 4'd3, 16'd77);
        issue(KIND_LOAD, '0, 4'd14, '0);
        issue(KIND_WITHDRAW, 27'd500000, '0, '0);
        issue(KIND_WITHDRAW, 27'd10001, '0, '0);
        issue(KIND_WITHDRAW, 27'd10000, '0, '0);
        issue(KIND_LOAD, '0, 4'd7, '0);
        issue(KIND_WITHDRAW, 27'd10200, '0, '0);

        settle();
        set_limits('0, AMT_ALL);
        issue(KIND_WITHDRAW, '0, '0, '0);
        issue(KIND_WITHDRAW, AMT_ALL, '0, '0);
        issue(KIND_DEPOSIT, AMT_ALL, '0, '0);

        // A minimum above the maximum refuses every withdrawal.
        settle();
        set_limits(AMT_ALL, '0);
        issue(KIND_WITHDRAW, 27'd5000, '0, '0);
        issue(KIND_WITHDRAW, '0, '0, '0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: set_limits(27'd10000, 27'd500000);
                1: set_limits('0, AMT_ALL);
                2: begin
                    lo = t_amount'($urandom_range(200000));
                    set_limits(lo, lo + t_amount'($urandom_range(3000000)));
                end
                3: begin
                    write_reg(REG_SPARE_LO, t_amount'($urandom));
                    write_reg(REG_SPARE_HI, t_amount'($urandom));
                    set_limits(27'd100, AMT_TOP);
                end
                4: begin
                    lo = t_amount'($urandom_range(100000, 1000));
                    set_limits(lo, lo);
                end
                5: set_limits(AMT_ALL, '0);
                default: set_limits(t_amount'($urandom), t_amount'($urandom));
            endcase

            // Restock every denomination so that withdrawals get past the stock check.
            for (int d = 0; d < NUM_DENOMS; d++) begin
                issue(KIND_LOAD, t_amount'($urandom), t_idx'(d),
                      VALUE_W'($urandom_range(65535, 2000)));
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                amt  = t_amount'($urandom);
                idx  = t_idx'($urandom);
                val  = VALUE_W'($urandom);
                if (pick < 15) begin
                    kind = KIND_LOAD;
                    sub  = $urandom_range(3);
                    if (sub == 0) begin
                        val = VALUE_W'($urandom_range(65535, 65400));
                    end else if (sub == 1) begin
                        val = VALUE_W'($urandom_range(50));
                    end
                end else if (pick < 47) begin
                    kind = KIND_DEPOSIT;
                    sub  = $urandom_range(19);
                    if (sub < 10) begin
                        amt = t_amount'($urandom_range(5000));
                    end else if (sub < 17) begin
                        amt = t_amount'($urandom_range(2000000));
                    end else if (sub < 19) begin
                        amt = t_amount'($urandom_range(AMT_TOP));
                    end
                end else if (pick < 95) begin
                    kind = KIND_WITHDRAW;
                    if ($urandom_range(4) != 0 && lim_lo <= lim_hi) begin
                        span = lim_hi - lim_lo;
                        if (span > 800000 && $urandom_range(9) != 0) span = 27'd800000;
                        amt = lim_lo + t_amount'($urandom_range(span));
                    end
                end else begin
                    kind = KIND_SPARE;
                end
                issue(kind, amt, idx, val);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
